// ----- design/cffp_pkg.sv -----
// ----------------------------------------------------------------------------
// cffp_pkg
// Shared types and constants for the camera frame field parser.
// ----------------------------------------------------------------------------
package cffp_pkg;

  localparam int WIN_DEPTH = 6;
  localparam int FILL_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_DEPTH);

  localparam logic [7:0] CLASS_PAYLOAD_SHADE = 8'h04;
  localparam logic [7:0] CLASS_PAYLOAD_HALF  = 8'h05;
  localparam logic [7:0] CLASS_PAYLOAD_SUN   = 8'h06;
  localparam logic [7:0] STATUS_RESET        = 8'h03;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_BYTE     = 3'd0,
    CFG_KIND_LOCATION = 3'd1,
    CFG_KIND_STATUS   = 3'd2,
    CFG_KIND_CLASS    = 3'd3,
    CFG_KIND_LAMP     = 3'd4,
    CFG_TAIL_BYTE     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLASS_SHADE = 2'd0,
    CLASS_HALF  = 2'd1,
    CLASS_SUN   = 2'd2
  } class_code_t;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] kind_location;
    logic [7:0] kind_status;
    logic [7:0] kind_class;
    logic [7:0] kind_lamp;
    logic [7:0] tail_byte;
  } cfg_t;

  typedef struct packed {
    logic lamp;
    logic cls;
    logic status;
    logic loc;
  } match_t;

  typedef struct packed {
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } payload_t;

endpackage

// ----- design/cffp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cffp_cfg_regs
// Configuration register file: frame marker bytes written by index.
// ----------------------------------------------------------------------------
module cffp_cfg_regs import cffp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_HEAD_BYTE:     cfg_nxt.head_byte     = wr_data;
        CFG_KIND_LOCATION: cfg_nxt.kind_location = wr_data;
        CFG_KIND_STATUS:   cfg_nxt.kind_status   = wr_data;
        CFG_KIND_CLASS:    cfg_nxt.kind_class    = wr_data;
        CFG_KIND_LAMP:     cfg_nxt.kind_lamp     = wr_data;
        CFG_TAIL_BYTE:     cfg_nxt.tail_byte     = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/cffp_window.sv -----
// ----------------------------------------------------------------------------
// cffp_window
// Six-byte history window with fill count and frame end detection.
// ----------------------------------------------------------------------------
module cffp_window import cffp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] cur_byte,
  input  logic       buf_start,
  input  cfg_t       cfg,
  output match_t     match,
  output payload_t   payload
);

  logic [7:0]        win_r [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] eff_fill;
  logic              tail_hit;

  // a new buffer empties the window before this byte is checked
  assign eff_fill = buf_start ? '0 : fill_r;
  assign tail_hit = (cur_byte == cfg.tail_byte);

  always_comb begin
    match.loc    = (eff_fill >= FILL_W'(6)) && (win_r[5] == cfg.head_byte) &&
                   (win_r[4] == cfg.kind_location) && tail_hit;
    match.status = (eff_fill >= FILL_W'(3)) && (win_r[2] == cfg.head_byte) &&
                   (win_r[1] == cfg.kind_status) && tail_hit;
    match.cls    = (eff_fill >= FILL_W'(3)) && (win_r[2] == cfg.head_byte) &&
                   (win_r[1] == cfg.kind_class) && tail_hit;
    match.lamp   = (eff_fill >= FILL_W'(2)) && (win_r[1] == cfg.head_byte) &&
                   (win_r[0] == cfg.kind_lamp) && tail_hit;
  end

  assign payload.b3 = win_r[3];
  assign payload.b2 = win_r[2];
  assign payload.b1 = win_r[1];
  assign payload.b0 = win_r[0];

  assign fill_nxt = (eff_fill == FILL_MAX) ? FILL_MAX : eff_fill + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (step) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win_r[0] <= cur_byte;
      for (int k = 1; k < WIN_DEPTH; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

endmodule

// ----- design/cffp_track.sv -----
// ----------------------------------------------------------------------------
// cffp_track
// Tracked fields updated by matched frames; these registers drive the result.
// ----------------------------------------------------------------------------
module cffp_track import cffp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  match_t      match,
  input  payload_t    payload,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [7:0]  status_value,
  output logic [1:0]  class_code,
  output logic        target_found,
  output logic        light_on
);

  logic [15:0] x_r, x_nxt;
  logic [15:0] y_r, y_nxt;
  logic [7:0]  status_r, status_nxt;
  class_code_t class_r, class_nxt;
  logic        found_r, found_nxt;
  logic        light_r, light_nxt;

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    status_nxt = status_r;
    class_nxt  = class_r;
    found_nxt  = found_r;
    light_nxt  = light_r;
    if (match.loc) begin
      x_nxt     = {payload.b3, payload.b2};
      y_nxt     = {payload.b1, payload.b0};
      found_nxt = 1'b1;
      light_nxt = 1'b0;
    end
    if (match.status) begin
      status_nxt = payload.b0;
    end
    if (match.cls) begin
      case (payload.b0)
        CLASS_PAYLOAD_SHADE: class_nxt = CLASS_SHADE;
        CLASS_PAYLOAD_HALF:  class_nxt = CLASS_HALF;
        CLASS_PAYLOAD_SUN:   class_nxt = CLASS_SUN;
        default:             class_nxt = class_r;
      endcase
    end
    // lamp starts latest in the window, so it applies last
    if (match.lamp) begin
      found_nxt = 1'b0;
      light_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      status_r <= STATUS_RESET;
      class_r  <= CLASS_SHADE;
      found_r  <= 1'b0;
      light_r  <= 1'b0;
    end else if (step) begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      status_r <= status_nxt;
      class_r  <= class_nxt;
      found_r  <= found_nxt;
      light_r  <= light_nxt;
    end
  end

  assign pos_x        = x_r;
  assign pos_y        = y_r;
  assign status_value = status_r;
  assign class_code   = class_r;
  assign target_found = found_r;
  assign light_on     = light_r;

endmodule

// ----- design/camera_frame_field_parser.sv -----
// ----------------------------------------------------------------------------
// camera_frame_field_parser
// Byte stream parser for location, status, class and lamp frames.
// ----------------------------------------------------------------------------
// Each accepted byte gives exactly one result item. A byte is captured in an
// input register, checked combinationally against the six-byte window and
// the marker registers, and its result lands in the output registers; a
// new byte is taken every cycle while results are drained, so throughput is
// one item per clock; result valid rises once the output registers load it.
// Backpressure on the result side stalls the input register.
// Configuration writes are taken at any time and should be made while idle.
// ----------------------------------------------------------------------------
module camera_frame_field_parser import cffp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_buffer_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_pos_x,
  output logic [15:0]          out_pos_y,
  output logic [7:0]           out_status_value,
  output logic [1:0]           out_class_code,
  output logic                 out_target_found,
  output logic                 out_light_on,
  output logic [3:0]           out_matched_kinds,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_t       cfg;
  match_t     match;
  payload_t   payload;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       out_valid_r;
  logic [3:0] matched_r;
  logic       step;

  // stage 1 item moves into the result registers
  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;
  assign cfg_ready = 1'b1;

  cffp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cffp_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cur_byte  (s1_byte_r),
    .buf_start (s1_start_r),
    .cfg       (cfg),
    .match     (match),
    .payload   (payload)
  );

  cffp_track u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .match        (match),
    .payload      (payload),
    .pos_x        (out_pos_x),
    .pos_y        (out_pos_y),
    .status_value (out_status_value),
    .class_code   (out_class_code),
    .target_found (out_target_found),
    .light_on     (out_light_on)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_buffer_start;
    end
    if (step) begin
      matched_r <= match;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_matched_kinds = matched_r;

endmodule
